// ----- rtl/tcch_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_pkg: shared types and constants for the compass heading block
// Payload structs, register indexes, CORDIC sizes and arctangent table.
// ----------------------------------------------------------------------------
package tcch_pkg;

    localparam int CORDIC_STEPS   = 16;
    localparam int COEF_FRAC_BITS = 14;
    localparam int TABLE_LEN      = 24;
    localparam int NSTEP          = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int STEP_W         = 5;

    localparam int CFG_W   = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
    localparam int ROT_W = 32;
    localparam int VEC_W = 53;

    localparam logic [CFG_W-1:0] COEF_ONE = CFG_W'(1) << COEF_FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HARD_IRON = 3'd0,
        CFG_ROW_X     = 3'd1,
        CFG_ROW_Y     = 3'd2,
        CFG_ROW_Z     = 3'd3,
        CFG_DECL      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] mag_z;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_x;
    } t_in;

    typedef struct packed {
        logic        [15:0] heading;
        logic signed [15:0] cal_z;
        logic signed [15:0] cal_y;
        logic signed [15:0] cal_x;
    } t_out;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_cal;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic                    flip;
    } t_rot;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic        [31:0]      z;
        logic                    zero;
    } t_vec;

    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680862;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41721;
            5'd15: v = 32'd20860;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2607;
            5'd19: v = 32'd1303;
            5'd20: v = 32'd651;
            5'd21: v = 32'd325;
            5'd22: v = 32'd162;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/tilt_compensated_compass_heading.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading: calibrated, tilt-compensated heading
// Hard/soft-iron calibration, CORDIC sine/cosine tilt correction and
// CORDIC atan2 heading with declination.
//
//   channel | valid       | stall        | payload
//   input   | i_in_valid  | o_in_stall   | i_in_data  (t_in)
//   output  | o_out_valid | i_out_stall  | o_out_data (t_out)
//   config  | i_cfg_we    | -            | i_cfg_idx, i_cfg_wdata
//
// One transaction per cycle while o_in_stall is low; the latency is set by the two
// CORDIC cell rows and the tilt multiplier stages.
// Synchronous active-low reset clears valids and restores the identity matrix.
// A full output register with a full skid stage stalls the input side.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  tcch_pkg::t_in                        i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output tcch_pkg::t_out                       o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [tcch_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tcch_pkg::CFG_W-1:0]           i_cfg_wdata
);

    localparam int NS   = tcch_pkg::NSTEP;
    localparam int LAST = 2 * NS + 3;
    localparam int FB   = tcch_pkg::COEF_FRAC_BITS;

    // configuration
    logic [tcch_pkg::CFG_W-1:0] r_hard;
    logic [tcch_pkg::CFG_W-1:0] r_row [3];
    logic [15:0]                r_decl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hard   <= '0;
            r_row[0] <= tcch_pkg::COEF_ONE;
            r_row[1] <= tcch_pkg::COEF_ONE << 16;
            r_row[2] <= tcch_pkg::COEF_ONE << 32;
            r_decl   <= '0;
        end else if (i_cfg_we) begin
            case (tcch_pkg::t_cfg_idx'(i_cfg_idx))
                tcch_pkg::CFG_HARD_IRON: r_hard   <= i_cfg_wdata;
                tcch_pkg::CFG_ROW_X:     r_row[0] <= i_cfg_wdata;
                tcch_pkg::CFG_ROW_Y:     r_row[1] <= i_cfg_wdata;
                tcch_pkg::CFG_ROW_Z:     r_row[2] <= i_cfg_wdata;
                tcch_pkg::CFG_DECL:      r_decl   <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // flow control
    logic   r_skid_valid;
    logic   en;
    logic   r_vld [LAST+1];
    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 0: offsets and angle fold
    logic signed [16:0] r_d [3];
    tcch_pkg::t_rot     rot_p [NS+1];
    tcch_pkg::t_rot     rot_r [NS+1];
    tcch_pkg::t_rot     r_rot0_p;
    tcch_pkg::t_rot     r_rot0_r;
    tcch_pkg::t_rot     n_rot0_p;
    tcch_pkg::t_rot     n_rot0_r;

    function automatic tcch_pkg::t_rot rot_init(input logic signed [15:0] ang);
        tcch_pkg::t_rot     v;
        logic signed [16:0] a;
        a = 17'(ang);
        v.flip = 1'b0;
        if (a > 17'sd16384) begin
            a = a - 17'sd32768;
            v.flip = 1'b1;
        end else if (a < -17'sd16384) begin
            a = a + 17'sd32768;
            v.flip = 1'b1;
        end
        v.x = tcch_pkg::GAIN_Q30;
        v.y = '0;
        v.z = {a[15:0], 16'd0};
        return v;
    endfunction

    assign n_rot0_p = rot_init(i_in_data.pitch_angle);
    assign n_rot0_r = rot_init(i_in_data.roll_angle);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0]   <= 17'(i_in_data.mag_x) - 17'(signed'(r_hard[15:0]));
            r_d[1]   <= 17'(i_in_data.mag_y) - 17'(signed'(r_hard[31:16]));
            r_d[2]   <= 17'(i_in_data.mag_z) - 17'(signed'(r_hard[47:32]));
            r_rot0_p <= n_rot0_p;
            r_rot0_r <= n_rot0_r;
        end
    end

    assign rot_p[0] = r_rot0_p;
    assign rot_r[0] = r_rot0_r;

    // rotation cell row
    for (genvar g = 0; g < NS; g++) begin : g_rot
        tcch_rot_cell u_p (
            .i_clk (i_clk),
            .i_en  (en),
            .i_step(tcch_pkg::STEP_W'(g)),
            .i_d   (rot_p[g]),
            .o_d   (rot_p[g+1])
        );
        tcch_rot_cell u_r (
            .i_clk (i_clk),
            .i_en  (en),
            .i_step(tcch_pkg::STEP_W'(g)),
            .i_d   (rot_r[g]),
            .o_d   (rot_r[g+1])
        );
    end

    // calibration: stage 1 products, stage 2 round and saturate
    logic signed [32:0] r_prod [3][3];
    tcch_pkg::t_cal     n_cal;
    tcch_pkg::t_cal     r_cal [2:LAST];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int m = 0; m < 3; m++) begin
                for (int n = 0; n < 3; n++) begin
                    r_prod[m][n] <= 33'(signed'(r_row[m][16*n +: 16])) * 33'(r_d[n]);
                end
            end
        end
    end

    function automatic logic signed [15:0] cal_sat(input logic signed [32:0] a,
                                                   input logic signed [32:0] b,
                                                   input logic signed [32:0] c);
        logic signed [34:0] s;
        logic signed [34:0] r;
        s = 35'(a) + 35'(b) + 35'(c) + (35'sd1 <<< (FB - 1));
        r = s >>> FB;
        if (r > 35'sd32767) begin
            return 16'sh7FFF;
        end else if (r < -35'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    assign n_cal.x = cal_sat(r_prod[0][0], r_prod[0][1], r_prod[0][2]);
    assign n_cal.y = cal_sat(r_prod[1][0], r_prod[1][1], r_prod[1][2]);
    assign n_cal.z = cal_sat(r_prod[2][0], r_prod[2][1], r_prod[2][2]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cal[2] <= n_cal;
            for (int k = 3; k <= LAST; k++) begin
                r_cal[k] <= r_cal[k-1];
            end
        end
    end

    // tilt stage 1: sines, cosines and first products
    logic signed [31:0] sp, cp, sr, cr;
    logic signed [63:0] ssp_w, scp_w;
    logic signed [47:0] r_cx_cp, r_cz_sp, r_cy_cr;
    logic signed [31:0] r_ssp, r_scp;

    assign sp = rot_p[NS].flip ? -rot_p[NS].y : rot_p[NS].y;
    assign cp = rot_p[NS].flip ? -rot_p[NS].x : rot_p[NS].x;
    assign sr = rot_r[NS].flip ? -rot_r[NS].y : rot_r[NS].y;
    assign cr = rot_r[NS].flip ? -rot_r[NS].x : rot_r[NS].x;
    assign ssp_w = (64'(sr) * 64'(sp)) >>> 30;
    assign scp_w = (64'(sr) * 64'(cp)) >>> 30;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx_cp <= 48'(r_cal[NS].x) * 48'(cp);
            r_cz_sp <= 48'(r_cal[NS].z) * 48'(sp);
            r_cy_cr <= 48'(r_cal[NS].y) * 48'(cr);
            r_ssp   <= ssp_w[31:0];
            r_scp   <= scp_w[31:0];
        end
    end

    // tilt stage 2: horizontal x and cross products
    logic signed [48:0] r_xh;
    logic signed [47:0] r_cx_ssp, r_cz_scp, r_cy_cr2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xh     <= 49'(r_cx_cp) + 49'(r_cz_sp);
            r_cx_ssp <= 48'(r_cal[NS+1].x) * 48'(r_ssp);
            r_cz_scp <= 48'(r_cal[NS+1].z) * 48'(r_scp);
            r_cy_cr2 <= r_cy_cr;
        end
    end

    // tilt stage 3: horizontal y and vector set-up
    logic signed [tcch_pkg::VEC_W-1:0] xw, yw;
    tcch_pkg::t_vec n_vec0;
    tcch_pkg::t_vec r_vec0;
    tcch_pkg::t_vec vec [NS+1];

    always_comb begin
        xw = tcch_pkg::VEC_W'(r_xh);
        yw = tcch_pkg::VEC_W'(r_cx_ssp) + tcch_pkg::VEC_W'(r_cy_cr2)
           - tcch_pkg::VEC_W'(r_cz_scp);
        n_vec0.zero = (xw == '0) && (yw == '0);
        if (xw < 0) begin
            n_vec0.x = -xw;
            n_vec0.y = -yw;
            n_vec0.z = 32'h8000_0000;
        end else begin
            n_vec0.x = xw;
            n_vec0.y = yw;
            n_vec0.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vec0 <= n_vec0;
        end
    end

    assign vec[0] = r_vec0;

    // vectoring cell row
    for (genvar g = 0; g < NS; g++) begin : g_vec
        tcch_vec_cell u_v (
            .i_clk (i_clk),
            .i_en  (en),
            .i_step(tcch_pkg::STEP_W'(g)),
            .i_d   (vec[g]),
            .o_d   (vec[g+1])
        );
    end

    // heading and output register with skid stage
    logic [31:0]    zr;
    tcch_pkg::t_out p_data;
    tcch_pkg::t_out r_out;
    tcch_pkg::t_out r_skid;
    logic           r_out_valid;

    assign zr             = (vec[NS].zero ? 32'd0 : vec[NS].z) + 32'd32768;
    assign p_data.heading = zr[31:16] + r_decl;
    assign p_data.cal_x   = r_cal[LAST].x;
    assign p_data.cal_y   = r_cal[LAST].y;
    assign p_data.cal_z   = r_cal[LAST].z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            r_out_valid  <= r_skid_valid || r_vld[LAST];
            r_skid_valid <= 1'b0;
        end else if (en && r_vld[LAST]) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out <= r_skid_valid ? r_skid : p_data;
        end else if (en) begin
            r_skid <= p_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/tcch_rot_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_rot_cell: one rotation-mode CORDIC step
// Turns the vector towards the residual angle and registers the result.
// ----------------------------------------------------------------------------
module tcch_rot_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [tcch_pkg::STEP_W-1:0]   i_step,
    input  tcch_pkg::t_rot                i_d,
    output tcch_pkg::t_rot                o_d
);

    tcch_pkg::t_rot r_d;
    tcch_pkg::t_rot n_d;
    logic signed [tcch_pkg::ROT_W-1:0] dx;
    logic signed [tcch_pkg::ROT_W-1:0] dy;
    logic signed [tcch_pkg::ROT_W-1:0] at;

    always_comb begin
        dx = i_d.y >>> i_step;
        dy = i_d.x >>> i_step;
        at = tcch_pkg::ROT_W'(signed'(tcch_pkg::atan_turn(i_step)));
        n_d = i_d;
        if (i_d.z >= 0) begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - at;
        end else begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ----- rtl/tcch_vec_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_vec_cell: one vectoring-mode CORDIC step
// Drives the vector towards the x axis and accumulates the angle.
// ----------------------------------------------------------------------------
module tcch_vec_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [tcch_pkg::STEP_W-1:0]   i_step,
    input  tcch_pkg::t_vec                i_d,
    output tcch_pkg::t_vec                o_d
);

    tcch_pkg::t_vec r_d;
    tcch_pkg::t_vec n_d;
    logic signed [tcch_pkg::VEC_W-1:0] dx;
    logic signed [tcch_pkg::VEC_W-1:0] dy;
    logic [31:0] at;

    always_comb begin
        dx = i_d.y >>> i_step;
        dy = i_d.x >>> i_step;
        at = tcch_pkg::atan_turn(i_step);
        n_d = i_d;
        if (i_d.y >= 0) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + at;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ----- rtl/tcch_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcch_checker: port-level checks for the compass heading block
// Output hold and payload stability under stall, and input stall origin.
// ----------------------------------------------------------------------------
module tcch_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           o_in_stall,
    input  logic           o_out_valid,
    input  logic           i_out_stall,
    input  tcch_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled output payload changed");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_stall_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall raised without output back-pressure");

endmodule

bind tilt_compensated_compass_heading tcch_checker u_tcch_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);

// ----- dv/tilt_compensated_compass_heading_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_tb: self-checking bench for the heading block
// Drives directed and random samples through valid/stall handshakes with
// random idling and a long output hold-off, predicts calibration and heading
// per sample and compares every output transaction in order.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading_tb;

    localparam int LATENCY  = 2 * tcch_pkg::NSTEP + 5;
    localparam int WATCHDOG = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    tcch_pkg::t_in  i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    tcch_pkg::t_out o_out_data;
    logic        i_cfg_we;
    logic [tcch_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [tcch_pkg::CFG_W-1:0]     i_cfg_wdata;

    tilt_compensated_compass_heading dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    logic [47:0] hard_iron, row_x, row_y, row_z;
    logic [15:0] decl;

    tcch_pkg::t_in  sample_q[$];
    tcch_pkg::t_out heading_q[$];
    int   mismatches;
    int   idle_pct;
    int   hold_off;
    bit   quiet_out;
    int   idle_cycles;
    bit   timed_out;

    function automatic longint lane16(logic [47:0] p, int k);
        return longint'($signed(p[16*k +: 16]));
    endfunction

    function automatic longint asr_n(longint v, int n);
        return v >>> n;
    endfunction

    function automatic logic signed [15:0] cal_axis(logic [47:0] row, longint d[3]);
        longint acc, r;
        acc = lane16(row, 0) * d[0] + lane16(row, 1) * d[1] + lane16(row, 2) * d[2];
        r = asr_n(acc + (longint'(1) << (tcch_pkg::COEF_FRAC_BITS - 1)),
                  tcch_pkg::COEF_FRAC_BITS);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    function automatic void tilt_sincos(longint ang, output longint s, output longint c);
        bit     fl;
        longint x, y, z, dx, dy;
        fl = 0;
        x = 652032874;
        y = 0;
        if (ang > 16384 || ang < -16384) begin
            fl = 1;
            ang += (ang > 0) ? -32768 : 32768;
        end
        z = ang * 65536;
        for (int i = 0; i < tcch_pkg::NSTEP; i++) begin
            dx = asr_n(y, i);
            dy = asr_n(x, i);
            if (z >= 0) begin
                x -= dx; y += dy;
                z -= longint'(tcch_pkg::atan_turn(tcch_pkg::STEP_W'(i)));
            end else begin
                x += dx; y -= dy;
                z += longint'(tcch_pkg::atan_turn(tcch_pkg::STEP_W'(i)));
            end
        end
        s = fl ? -y : y;
        c = fl ? -x : x;
    endfunction

    function automatic logic [31:0] field_angle(longint x, longint y);
        logic [31:0] z;
        longint dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < tcch_pkg::NSTEP; i++) begin
            dx = asr_n(y, i);
            dy = asr_n(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += tcch_pkg::atan_turn(tcch_pkg::STEP_W'(i));
            end else begin
                x -= dx; y += dy; z -= tcch_pkg::atan_turn(tcch_pkg::STEP_W'(i));
            end
        end
        return z;
    endfunction

    function automatic tcch_pkg::t_out predict_heading(tcch_pkg::t_in s);
        tcch_pkg::t_out r;
        longint d[3];
        longint cx, cy, cz, sp, cp, sr, cr, xh, yh;
        logic [31:0] z;
        d[0] = longint'(s.mag_x) - lane16(hard_iron, 0);
        d[1] = longint'(s.mag_y) - lane16(hard_iron, 1);
        d[2] = longint'(s.mag_z) - lane16(hard_iron, 2);
        r.cal_x = cal_axis(row_x, d);
        r.cal_y = cal_axis(row_y, d);
        r.cal_z = cal_axis(row_z, d);
        cx = longint'(r.cal_x);
        cy = longint'(r.cal_y);
        cz = longint'(r.cal_z);
        tilt_sincos(longint'(s.pitch_angle), sp, cp);
        tilt_sincos(longint'(s.roll_angle), sr, cr);
        xh = cx * cp + cz * sp;
        yh = cx * asr_n(sr * sp, 30) + cy * cr - cz * asr_n(sr * cp, 30);
        z = field_angle(xh, yh);
        r.heading = 16'((z + 32'd32768) >> 16) + decl;
        return r;
    endfunction

    task automatic write_reg(tcch_pkg::t_cfg_idx idx, logic [47:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tcch_pkg::CFG_HARD_IRON: hard_iron = v;
            tcch_pkg::CFG_ROW_X:     row_x = v;
            tcch_pkg::CFG_ROW_Y:     row_y = v;
            tcch_pkg::CFG_ROW_Z:     row_z = v;
            tcch_pkg::CFG_DECL:      decl = v[15:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (sample_q.size() != 0 || heading_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic tcch_pkg::t_in rnd_sample();
        tcch_pkg::t_in s;
        s.mag_x = rnd16();
        s.mag_y = rnd16();
        s.mag_z = rnd16();
        s.pitch_angle = rnd16();
        s.roll_angle = rnd16();
        return s;
    endfunction

    function automatic logic [47:0] rnd_coefs();
        logic [47:0] v;
        for (int k = 0; k < 3; k++)
            v[16*k +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                          : 16'(int'($urandom_range(0, 32768)) - 16384);
        return v;
    endfunction

    function automatic tcch_pkg::t_in mk(int x, int y, int z, int p, int r);
        tcch_pkg::t_in s;
        s.mag_x = 16'(x); s.mag_y = 16'(y); s.mag_z = 16'(z);
        s.pitch_angle = 16'(p); s.roll_angle = 16'(r);
        return s;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid) void'(sample_q.pop_front());
            if (sample_q.size() > (i_in_valid ? 1 : 0) &&
                $urandom_range(0, 99) >= idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= sample_q[i_in_valid ? 1 : 0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            heading_q.push_back(predict_heading(i_in_data));
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (heading_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected output %h", o_out_data);
                end else begin
                    tcch_pkg::t_out e;
                    e = heading_q.pop_front();
                    if (e.cal_x !== o_out_data.cal_x || e.cal_y !== o_out_data.cal_y ||
                        e.cal_z !== o_out_data.cal_z || e.heading !== o_out_data.heading) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp %h act %h", e, o_out_data);
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off    <= hold_off - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !quiet_out && $urandom_range(0, 99) < 16;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (sample_q.size() != 0 || heading_q.size() != 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) timed_out = 1;
        end
    end

    initial begin
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_data = '0; i_out_stall = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = tcch_pkg::CFG_HARD_IRON; i_cfg_wdata = '0;
        mismatches = 0; idle_pct = 16; hold_off = 0; quiet_out = 0;
        idle_cycles = 0; timed_out = 0;
        hard_iron = '0; row_x = 48'd16384; row_y = 48'd16384 << 16;
        row_z = 48'd16384 << 32; decl = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed at reset settings
        sample_q.push_back(mk(0, 0, 0, 0, 0));
        sample_q.push_back(mk(32767, 32767, 32767, 32767, 32767));
        sample_q.push_back(mk(-32768, -32768, -32768, -32768, -32768));
        sample_q.push_back(mk(-1000, 0, 0, 0, 0));
        sample_q.push_back(mk(1000, 0, 0, 0, 0));
        sample_q.push_back(mk(0, 1000, 0, 0, 0));
        sample_q.push_back(mk(0, -1000, 500, 16384, -16384));
        sample_q.push_back(mk(300, 200, 100, 16385, -16385));
        sample_q.push_back(mk(300, -200, 100, 20000, 30000));
        sample_q.push_back(mk(-300, -200, -100, -20000, -30000));
        sample_q.push_back(mk(0, 0, 1000, 8192, 8192));
        sample_q.push_back(mk(-1, -1, -1, 1, -1));
        drain();

        // extreme calibration: offsets and max gain saturate
        write_reg(tcch_pkg::CFG_HARD_IRON, {16'h8000, 16'h7fff, 16'h8000});
        write_reg(tcch_pkg::CFG_ROW_X, {16'h7fff, 16'h7fff, 16'h7fff});
        write_reg(tcch_pkg::CFG_ROW_Y, {16'h8000, 16'h8000, 16'h8000});
        write_reg(tcch_pkg::CFG_ROW_Z, 48'hffff_ffff_ffff);
        write_reg(tcch_pkg::CFG_DECL, 48'h7fff);
        for (int i = 0; i < 6; i++) sample_q.push_back(rnd_sample());
        sample_q.push_back(mk(32767, -32768, 32767, 0, 0));
        sample_q.push_back(mk(-32768, 32767, -32768, 100, -100));
        drain();
        write_reg(tcch_pkg::CFG_DECL, 48'h8000);
        write_reg(tcch_pkg::CFG_ROW_X, '0);
        write_reg(tcch_pkg::CFG_ROW_Z, '0);
        sample_q.push_back(mk(5, 5, 5, 0, 0));
        sample_q.push_back(mk(-5, 5, 5, 0, 0));
        drain();

        // random phases with fresh settings
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(tcch_pkg::CFG_HARD_IRON, {16'($urandom_range(0, 511) - 256),
                                      16'($urandom), 16'($urandom_range(0, 511) - 256)});
            write_reg(tcch_pkg::CFG_ROW_X, rnd_coefs());
            write_reg(tcch_pkg::CFG_ROW_Y, rnd_coefs());
            write_reg(tcch_pkg::CFG_ROW_Z, rnd_coefs());
            write_reg(tcch_pkg::CFG_DECL, 48'($urandom_range(0, 65535)));
            quiet_out = (ph == 2);
            idle_pct  = (ph == 2) ? 0 : 16;
            if (ph == 3) hold_off = 300;
            for (int i = 0; i < 106; i++) sample_q.push_back(rnd_sample());
            drain();
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/tcch_pkg.sv
rtl/tcch_rot_cell.sv
rtl/tcch_vec_cell.sv
rtl/tilt_compensated_compass_heading.sv
rtl/tcch_checker.sv
dv/tilt_compensated_compass_heading_tb.sv
